// ===== rtl/core/aes128_pkg.sv =====
// aes128_pkg: shared types, tables and round functions for the aes-128 pipeline
// used by aes128_block_cipher and aes128_round; no dependencies
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int RoundIdxW = 4;

    typedef logic [127:0] block_t;

    // configuration register indexes
    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow  = 1'b1;

    // command codes
    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;

    // per-stage control travelling with the data
    typedef struct packed {
        logic valid;
        logic decrypt;
    } stage_ctl_t;

    localparam logic [7:0] FwdSub [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] InvSub [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    localparam logic [7:0] RoundConst [11] = '{
        8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    // byte n of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input block_t b, input int n);
        return b[127-8*n -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t sub_bytes(input block_t s, input logic inverse);
        block_t r;
        for (int n = 0; n < 16; n++) begin
            r[127-8*n -: 8] = inverse ? InvSub[get_byte(s, n)] : FwdSub[get_byte(s, n)];
        end
        return r;
    endfunction

    function automatic block_t shift_rows(input block_t s, input logic inverse);
        block_t r;
        for (int rr = 0; rr < 4; rr++) begin
            for (int c = 0; c < 4; c++) begin
                if (inverse) begin
                    r[127-8*(rr+4*((c+rr)%4)) -: 8] = get_byte(s, rr + 4*c);
                end
                else begin
                    r[127-8*(rr+4*c) -: 8] = get_byte(s, rr + 4*((c+rr)%4));
                end
            end
        end
        return r;
    endfunction

    function automatic block_t mix_columns(input block_t s, input logic inverse);
        block_t r;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
            z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
            if (inverse) begin
                // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
                r[127-8*(4*c)   -: 8] = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
                r[127-8*(4*c+1) -: 8] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
                r[127-8*(4*c+2) -: 8] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
                r[127-8*(4*c+3) -: 8] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
            end
            else begin
                r[127-8*(4*c)   -: 8] = x0 ^ (x1^a1) ^ a2 ^ a3;
                r[127-8*(4*c+1) -: 8] = a0 ^ x1 ^ (x2^a2) ^ a3;
                r[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ x2 ^ (x3^a3);
                r[127-8*(4*c+3) -: 8] = (x0^a0) ^ a1 ^ a2 ^ x3;
            end
        end
        return r;
    endfunction

    // one key schedule step: round key r-1 to round key r
    function automatic block_t next_round_key(input block_t k, input int r);
        logic [31:0] t, w0, w1, w2, w3;
        t  = k[31:0];
        t  = {FwdSub[t[23:16]] ^ RoundConst[r], FwdSub[t[15:8]], FwdSub[t[7:0]],
              FwdSub[t[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== rtl/core/aes128_round.sv =====
// aes128_round: one pipeline stage holding one cipher round of either direction
// depends on aes128_pkg
module aes128_round
    import aes128_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  stage_ctl_t       ctl_in,
    input  block_t           state_in,
    input  block_t           enc_key,
    input  block_t           dec_key,
    input  logic             last,
    output stage_ctl_t       ctl_out,
    output block_t           state_out
);

    stage_ctl_t ctl_reg;
    block_t     state_reg;
    block_t     state_next;
    block_t     t0, t1;

    // forward: sub, shift, mix, key; inverse: sub, shift, key, mix; mix is skipped when last is set
    always_comb
    begin
        t0 = shift_rows(sub_bytes(state_in, ctl_in.decrypt), ctl_in.decrypt);
        if (ctl_in.decrypt == CmdDecrypt)
        begin
            t1         = t0 ^ dec_key;
            state_next = last ? t1 : mix_columns(t1, 1'b1);
        end
        else
        begin
            t1         = last ? t0 : mix_columns(t0, 1'b0);
            state_next = t1 ^ enc_key;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // data register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;

endmodule

// ===== rtl/core/aes128_block_cipher.sv =====
// aes128_block_cipher: pipelined aes-128 encrypt and decrypt, one block per cycle while not stalled
// depends on aes128_pkg and aes128_round
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data     | in
//  input    | in_valid in_ready command block_high/low   | in
//  output   | out_valid out_ready out_high out_low       | out
//
// eleven register stages (whitening plus ten rounds), one block per cycle
// sustained while out_ready and key settling allow. the round key chain
// must settle, so in_ready stays low after reset and after each key write
// until a settle counter runs out. reset clears valid bits and key.
// a stall on out_ready freezes the whole pipeline; no beat is lost or repeated.
module aes128_block_cipher
    import aes128_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_high,
    output logic [63:0] out_low
);

    logic [63:0] key_high_reg, key_low_reg;
    block_t      rkey_reg [NumRounds+1];
    block_t      rkey_next [NumRounds+1];
    stage_ctl_t  ctl [NumRounds+1];
    block_t      st  [NumRounds+1];
    stage_ctl_t  ctl0_reg;
    block_t      st0_reg;
    logic        advance;
    block_t      blk_in;
    logic [RoundIdxW-1:0] settle_reg;
    logic        key_ready;

    assign cfg_ready = 1'b1;
    assign advance   = !ctl[NumRounds].valid || out_ready;
    assign key_ready = (settle_reg == '0);
    assign in_ready  = advance && key_ready;
    assign blk_in    = {block_high, block_low};

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgKeyHigh: key_high_reg <= cfg_data;
                CfgKeyLow:  key_low_reg  <= cfg_data;
                default:    key_high_reg <= key_high_reg;
            endcase
        end
    end

    // hold off input until the round key chain has settled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= RoundIdxW'(NumRounds + 1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            settle_reg <= RoundIdxW'(NumRounds + 1);
        end
        else if (!key_ready)
        begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    // round keys, one schedule step per entry
    always_comb
    begin
        rkey_next[0] = {key_high_reg, key_low_reg};
        for (int r = 1; r <= NumRounds; r++)
        begin
            rkey_next[r] = next_round_key(rkey_reg[r-1], r);
        end
    end

    // round key chain, one register per entry; settles entry by entry after a key write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= NumRounds; r++)
            begin
                rkey_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r <= NumRounds; r++)
            begin
                rkey_reg[r] <= rkey_next[r];
            end
        end
    end

    // whitening stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (advance)
        begin
            ctl0_reg <= '{valid: in_valid && key_ready, decrypt: command};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st0_reg <= blk_in ^ ((command == CmdDecrypt) ? rkey_reg[NumRounds] : rkey_reg[0]);
        end
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = st0_reg;

    // round stages
    for (genvar g = 1; g <= NumRounds; g++)
    begin : g_round
        aes128_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .ctl_in    (ctl[g-1]),
            .state_in  (st[g-1]),
            .enc_key   (rkey_reg[g]),
            .dec_key   (rkey_reg[NumRounds-g]),
            .last      (g == NumRounds),
            .ctl_out   (ctl[g]),
            .state_out (st[g])
        );
    end

    assign out_valid = ctl[NumRounds].valid;
    assign out_high  = st[NumRounds][127:64];
    assign out_low   = st[NumRounds][63:0];

endmodule

// ===== rtl/core/aes128_checker.sv =====
// aes128_checker: port-level assertions for aes128_block_cipher
// depends on aes128_block_cipher, bound to it below
module aes128_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_high,
    input logic [63:0] out_low
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
        else $error("result beat changed under stall");

    // input is held off while the round keys settle after a key write
    a_key_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> !in_ready)
        else $error("input taken right after key write");

    // a stall on the output stalls the input
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    // nothing in flight after reset gives no result
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result after reset");

endmodule

bind aes128_block_cipher aes128_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_high  (out_high),
    .out_low   (out_low)
);
